// File: src/midpoint_circle_rasterizer_core_defines.svh
// assertion macros for the midpoint circle rasterizer core
// no dependencies; the including module provides clk and rst
`ifndef MIDPOINT_CIRCLE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mcr_pkg.sv
// shared constants for the midpoint circle rasterizer
// no dependencies
`default_nettype none

package mcr_pkg;

  // display size defaults
  localparam int DispColsDefault = 8;
  localparam int DispRowsDefault = 16;

  // request kinds
  localparam logic [1:0] KindClear = 2'd0;
  localparam logic [1:0] KindDraw  = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;

  // datapath widths
  localparam int PixW   = 8;
  localparam int StepW  = 8;
  localparam int CoordW = 10;
  localparam int DecW   = 13;

  localparam logic [PixW-1:0] PixelOn  = 8'hFF;
  localparam logic [PixW-1:0] PixelOff = 8'h00;

  // decision variable terms
  localparam logic signed [DecW-1:0] DecInit    = 13'sd3;
  localparam logic signed [DecW-1:0] DecStepIn  = 13'sd6;
  localparam logic signed [DecW-1:0] DecStepOut = 13'sd10;

  localparam logic [2:0] OctLast = 3'd7;

endpackage

`default_nettype wire

// File: src/mcr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/mcr_octant.sv
// maps one of the eight symmetric circle points to a clipped store address
// depends on mcr_pkg
`default_nettype none

module mcr_octant #(
  parameter int COLS = mcr_pkg::DispColsDefault,
  parameter int ROWS = mcr_pkg::DispRowsDefault,
  parameter int AW   = ((COLS * ROWS) > 1) ? $clog2(COLS * ROWS) : 1
) (
  input  wire logic [6:0]                  cx,
  input  wire logic [6:0]                  cy,
  input  wire logic [mcr_pkg::StepW-1:0]   step_x,
  input  wire logic [mcr_pkg::StepW-1:0]   step_y,
  input  wire logic [2:0]                  sel,
  output logic                             hit,
  output logic      [AW-1:0]               addr
);

  localparam logic signed [mcr_pkg::CoordW-1:0] ColsS = mcr_pkg::CoordW'(COLS);
  localparam logic signed [mcr_pkg::CoordW-1:0] RowsS = mcr_pkg::CoordW'(ROWS);

  logic                               swap;
  logic                               neg_c;
  logic                               neg_r;
  logic [mcr_pkg::CoordW-1:0]         off_c;
  logic [mcr_pkg::CoordW-1:0]         off_r;
  logic signed [mcr_pkg::CoordW-1:0]  pc;
  logic signed [mcr_pkg::CoordW-1:0]  pr;

  // octant sign and swap pattern from the point index
  assign swap  = sel[0] ^ sel[1];
  assign neg_c = sel[1] ^ sel[2];
  assign neg_r = sel[2];

  assign off_c = swap ? mcr_pkg::CoordW'(step_y) : mcr_pkg::CoordW'(step_x);
  assign off_r = swap ? mcr_pkg::CoordW'(step_x) : mcr_pkg::CoordW'(step_y);

  assign pc = neg_c ? (mcr_pkg::CoordW'(cx) - off_c) : (mcr_pkg::CoordW'(cx) + off_c);
  assign pr = neg_r ? (mcr_pkg::CoordW'(cy) - off_r) : (mcr_pkg::CoordW'(cy) + off_r);

  assign hit = !pc[mcr_pkg::CoordW-1] && (pc < ColsS) &&
               !pr[mcr_pkg::CoordW-1] && (pr < RowsS);

  // row-major address, only meaningful when hit
  assign addr = AW'(AW'(pr) * AW'(COLS) + AW'(pc));

endmodule

`default_nettype wire

// File: src/midpoint_circle_rasterizer_core.sv
// top level of the midpoint circle rasterizer: sequencer around the frame store
// depends on mcr_pkg, mcr_ram, mcr_octant and the assertion macro header
`default_nettype none

// Midpoint circle rasterizer over a DISP_COLS x DISP_ROWS byte frame store
// (row-major). Each request returns exactly one result. kind 0 clears the
// store, kind 1 draws a circle outline of value 0xFF, kind 2 reads one pixel
// back (zero when off display); the result of every kind but a read is zero.
// The store is a single ram with one write port and one read port, and the
// write port sets the timing. A clear sweeps every address and then posts
// the result; a draw visits the eight symmetric points in turn on each step
// of the midpoint walk, about r/1.41 + 1 steps, and then posts the result; a
// read fetches its pixel from the store and then posts it; a rejected draw,
// an off-display read or an unused kind posts its result directly.
// The next request is taken on the cycle after the result is posted. After
// reset the block runs a clearing pass over the whole store during which no
// request is taken. One request is worked on at a time; a finished result
// sits in the output register, and the next request is taken while it waits.
module midpoint_circle_rasterizer_core #(
  parameter int DISP_COLS = mcr_pkg::DispColsDefault,
  parameter int DISP_ROWS = mcr_pkg::DispRowsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                kind,
  input  wire logic [7:0]                col,
  input  wire logic [7:0]                row,
  input  wire logic [6:0]                radius,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [mcr_pkg::PixW-1:0]  pixel_value
);

`include "midpoint_circle_rasterizer_core_defines.svh"

  localparam int Depth = DISP_COLS * DISP_ROWS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAW,
    S_READ,
    S_PUT
  } state_t;

  state_t                            state;
  logic [AW-1:0]                     clr_cnt;
  logic                              emit;      // clear was requested, post a result
  logic [6:0]                        cx;
  logic [6:0]                        cy;
  logic [mcr_pkg::StepW-1:0]         step_x;
  logic [mcr_pkg::StepW-1:0]         step_y;
  logic signed [mcr_pkg::DecW-1:0]   decision;
  logic [2:0]                        oct;
  logic [mcr_pkg::PixW-1:0]          result;

  // next walk position
  logic [mcr_pkg::StepW-1:0]         step_x_next;
  logic [mcr_pkg::StepW-1:0]         step_y_next;
  logic signed [mcr_pkg::DecW-1:0]   decision_next;
  logic signed [mcr_pkg::DecW-1:0]   x4;
  logic signed [mcr_pkg::DecW-1:0]   y4;

  logic                              in_ok;     // request taken this cycle
  logic                              center_in;
  logic                              draw_ok;
  logic [AW-1:0]                     pix_addr;

  logic                              pt_hit;
  logic [AW-1:0]                     pt_addr;

  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [mcr_pkg::PixW-1:0]          ram_wdata;
  logic                              ram_re;
  logic [mcr_pkg::PixW-1:0]          ram_rdata;

  // only the idle state takes requests
  assign in_stall = (state != S_IDLE);
  assign in_ok    = in_valid && (state == S_IDLE);

  // center or read pixel inside the display
  assign center_in = (9'(col) < 9'(DISP_COLS)) && (9'(row) < 9'(DISP_ROWS));
  assign draw_ok   = center_in && (radius != 7'd0);
  assign pix_addr  = AW'(AW'(row) * AW'(DISP_COLS) + AW'(col));

  // midpoint step: inside goes right, outside goes right and down
  assign x4 = $signed({3'b000, step_x, 2'b00});
  assign y4 = $signed({3'b000, step_y, 2'b00});

  always_comb begin
    step_x_next = step_x + 8'd1;
    if (decision[mcr_pkg::DecW-1]) begin
      decision_next = decision + x4 + mcr_pkg::DecStepIn;
      step_y_next   = step_y;
    end else begin
      decision_next = decision + x4 - y4 + mcr_pkg::DecStepOut;
      step_y_next   = step_y - 8'd1;
    end
  end

  // current symmetric point
  mcr_octant #(
    .COLS (DISP_COLS),
    .ROWS (DISP_ROWS),
    .AW   (AW)
  ) u_octant (
    .cx     (cx),
    .cy     (cy),
    .step_x (step_x),
    .step_y (step_y),
    .sel    (oct),
    .hit    (pt_hit),
    .addr   (pt_addr)
  );

  // write port: clear sweep or clipped plot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = mcr_pkg::PixelOff;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_DRAW) begin
      ram_we    = pt_hit;
      ram_waddr = pt_addr;
      ram_wdata = mcr_pkg::PixelOn;
    end
  end

  // read port: issued straight from the request, data lands next cycle;
  // writes never run while idle, so no forwarding is needed
  assign ram_re = in_ok && (kind == mcr_pkg::KindRead) && center_in;

  mcr_ram #(
    .WIDTH (mcr_pkg::PixW),
    .DEPTH (Depth),
    .AW    (AW)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      emit      <= 1'b0;
      oct       <= '0;
      out_valid <= 1'b0;
    end else begin
      // result taken downstream, unless a new one is posted in its place
      if (out_valid && !out_stall && (state != S_PUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == LastAddr) begin
            clr_cnt <= '0;
            result  <= mcr_pkg::PixelOff;
            state   <= emit ? S_PUT : S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            result <= mcr_pkg::PixelOff;
            unique case (kind)
              mcr_pkg::KindClear: begin
                emit  <= 1'b1;
                state <= S_CLEAR;
              end
              mcr_pkg::KindDraw: begin
                if (draw_ok) begin
                  cx       <= col[6:0];
                  cy       <= row[6:0];
                  step_x   <= '0;
                  step_y   <= {1'b0, radius};
                  decision <= mcr_pkg::DecInit - $signed({5'b00000, radius, 1'b0});
                  oct      <= '0;
                  state    <= S_DRAW;
                end else begin
                  state <= S_PUT;
                end
              end
              mcr_pkg::KindRead: begin
                state <= center_in ? S_READ : S_PUT;
              end
              default: begin
                state <= S_PUT;
              end
            endcase
          end
        end

        S_DRAW: begin
          oct <= oct + 3'd1;
          if (oct == mcr_pkg::OctLast) begin
            step_x   <= step_x_next;
            step_y   <= step_y_next;
            decision <= decision_next;
            if (step_x_next > step_y_next) begin
              state <= S_PUT;
            end
          end
        end

        S_READ: begin
          result <= ram_rdata;
          state  <= S_PUT;
        end

        S_PUT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            pixel_value <= result;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- assertions ----

  // the walk stays in its first octant while plotting
  `MCR_ASSERT_NOW(a_walk_octant, state == S_DRAW, step_x <= step_y, "walk left octant")

  // clipping never lets a write fall outside the store
  `MCR_ASSERT_NOW(a_write_in_range, ram_we, ram_waddr <= LastAddr, "write beyond store")

  // a read always finds the port free of writes
  `MCR_ASSERT_NOW(a_read_no_write, ram_re, !ram_we, "read overlaps write")

  // read data is captured on the cycle after the port is read
  `MCR_ASSERT_NEXT(a_read_follows, ram_re, state == S_READ, "read data not captured")

endmodule

`default_nettype wire
